/* rtl/pccmr_pkg.sv */
`default_nettype none
package pccmr_pkg;
    localparam int MaxPoints = 256;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = IdxW + 1;
    localparam int CoordW    = 24;
    localparam int SumW      = CoordW + CntW;
    localparam int PointW    = 3 * CoordW;
    localparam int DiffW     = CoordW + 2;
    localparam int SqW       = 2 * DiffW;
    localparam int D2W       = SqW + 2;
    localparam int RootW     = (D2W + 1) / 2;
    localparam int RsumW     = RootW + CntW;
    localparam int RadW      = 25;
    localparam int QueueDepth = 4;
    localparam int QueueIdxW  = $clog2(QueueDepth);

    typedef struct packed {
        logic [PointW-1:0] point;
        logic              store;
        logic              last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_LOAD, ST_DIV_C, ST_WALK, ST_DIV_R, ST_OUT
    } t_state;
endpackage
`default_nettype wire

/* rtl/pccmr_ram.sv */
`default_nettype none
module pccmr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/pccmr_front.sv */
`default_nettype none
module pccmr_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [pccmr_pkg::PointW-1:0] i_point,
    input  wire logic                  i_last,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output pccmr_pkg::t_cmd            o_cmd
);
    import pccmr_pkg::*;
    // queue of classified points; store bit tells back whether the point fits
    t_cmd r_q [QueueDepth];
    logic [QueueIdxW-1:0] r_wp, r_rp;
    logic [QueueIdxW:0] r_cnt;
    logic [CntW-1:0] r_seen;
    logic push, pop;
    t_cmd cmd;

    function automatic logic [QueueIdxW:0] CntWQ();
        return (QueueIdxW+1)'(QueueDepth);
    endfunction

    assign o_ready = (r_cnt != CntWQ());
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop = o_valid && i_ready;
    assign o_cmd = r_q[r_rp];

    always_comb begin
        cmd.point = i_point;
        cmd.store = (r_seen < CntW'(MaxPoints));
        cmd.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_seen <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
                if (i_last) begin
                    r_seen <= '0;
                end else if (cmd.store) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QueueIdxW+1)'(push) - (QueueIdxW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/pccmr_back.sv */
`default_nettype none
module pccmr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  pccmr_pkg::t_cmd           i_cmd,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [3*pccmr_pkg::CoordW+pccmr_pkg::RadW+1-1:0] o_result
);
    import pccmr_pkg::*;

    t_state r_state, n_state;
    logic [CntW-1:0] r_cnt;
    logic signed [SumW-1:0] r_sum [3];
    logic r_ovf;
    logic signed [CoordW-1:0] r_cen [3];
    logic [IdxW-1:0] r_ridx;
    logic [CntW-1:0] r_walk;
    logic [RsumW-1:0] r_rsum;
    // divider
    logic [1:0] r_dsel;
    logic [SumW-1:0] r_quo, r_rem;
    logic [5:0] r_dbit;
    logic r_dneg;
    // walk pipeline
    logic [PointW-1:0] rd;
    logic r_v1, r_v2, r_v3;
    logic [SqW-1:0] r_sq [3];
    logic [D2W-1:0] r_d2;
    logic [D2W-1:0] r_sx;
    logic [RootW-1:0] r_root;
    logic [5:0] r_sstep;
    logic r_sbusy, r_sdone;
    logic signed [DiffW-1:0] dif [3];
    logic [DiffW-1:0] mag [3];
    logic [RootW+1:0] trial;
    logic [D2W-1:0] srem_try;
    logic [SumW:0] dtry;
    logic [SumW-1:0] dividend;
    logic accept;

    assign o_ready = (r_state == ST_LOAD);
    assign accept = i_valid && o_ready;

    pccmr_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
        .i_clk(i_clk),
        .i_we(accept && i_cmd.store),
        .i_waddr(r_cnt[IdxW-1:0]),
        .i_wdata(i_cmd.point),
        .i_raddr(r_ridx),
        .o_rdata(rd)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k] = DiffW'(signed'(rd[k*CoordW +: CoordW])) - DiffW'(r_cen[k]);
            mag[k] = dif[k][DiffW-1] ? DiffW'(-dif[k]) : DiffW'(dif[k]);
        end
    end

    // restoring divide of |dividend| by count, one bit a cycle
    always_comb begin
        case (r_dsel)
            2'd0: dividend = r_sum[0];
            2'd1: dividend = r_sum[1];
            2'd2: dividend = r_sum[2];
            default: dividend = SumW'(r_rsum);
        endcase
        dtry = {r_rem, r_quo[SumW-1]} - (SumW+1)'(r_cnt);
    end

    // isqrt digit step
    always_comb begin
        trial = {r_root, 2'b01};
        srem_try = {r_sx[D2W-3:0], r_d2[D2W-1:D2W-2]} - D2W'(trial);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (accept && i_cmd.last) n_state = ST_DIV_C;
            ST_DIV_C: if (r_dbit == 6'(SumW) && r_dsel == 2'd2) n_state = ST_WALK;
            ST_WALK: if (r_walk == r_cnt && r_sdone) n_state = ST_DIV_R;
            ST_DIV_R: if (r_dbit == 6'(SumW)) n_state = ST_OUT;
            ST_OUT: if (i_ready) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
            r_dsel <= '0;
            r_dbit <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    r_dsel <= 2'd0;
                    r_dbit <= '0;
                    r_ridx <= '0;
                    r_walk <= '0;
                    r_rsum <= '0;
                    r_sdone <= 1'b0;
                    if (accept) begin
                        if (i_cmd.store) begin
                            r_cnt <= r_cnt + 1'b1;
                            for (int k = 0; k < 3; k++)
                                r_sum[k] <= r_sum[k] +
                                    SumW'(signed'(i_cmd.point[k*CoordW +: CoordW]));
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_dneg <= 1'b0;
                        r_rem <= '0;
                        r_quo <= '0;
                    end
                end
                ST_DIV_C, ST_DIV_R: begin
                    if (r_dbit == 0) begin
                        // load magnitude
                        r_dneg <= (r_dsel != 2'd3) && dividend[SumW-1];
                        r_quo <= dividend[SumW-1] && (r_dsel != 2'd3) ?
                                 SumW'(-dividend) : dividend;
                        r_rem <= '0;
                        r_dbit <= 6'd1;
                    end else begin
                        if (!dtry[SumW]) begin
                            r_rem <= dtry[SumW-1:0];
                            r_quo <= {r_quo[SumW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[SumW-2:0], r_quo[SumW-1]};
                            r_quo <= {r_quo[SumW-2:0], 1'b0};
                        end
                        if (r_dbit == 6'(SumW)) begin
                            r_dbit <= '0;
                        end else begin
                            r_dbit <= r_dbit + 1'b1;
                        end
                    end
                    if (r_dbit == 6'(SumW) && r_state == ST_DIV_C) begin
                        r_cen[r_dsel] <= r_dneg ? CoordW'(-{r_quo[SumW-2:0], ~dtry[SumW]})
                                                : CoordW'({r_quo[SumW-2:0], ~dtry[SumW]});
                        r_dsel <= r_dsel + 1'b1;
                    end
                end
                ST_WALK: begin
                    // read, square, sum, then digit-serial sqrt per point
                    r_v1 <= !r_v1 && !r_v2 && !r_v3 && !r_sbusy && r_walk != r_cnt
                            && !r_sdone;
                    r_v2 <= r_v1;
                    if (r_v2) begin
                        for (int k = 0; k < 3; k++)
                            r_sq[k] <= SqW'(mag[k]) * SqW'(mag[k]);
                    end
                    r_v3 <= r_v2;
                    if (r_v3) begin
                        r_d2 <= D2W'(r_sq[0]) + D2W'(r_sq[1]) + D2W'(r_sq[2]);
                        r_sx <= '0;
                        r_root <= '0;
                        r_sstep <= '0;
                        r_sbusy <= 1'b1;
                    end
                    if (r_sbusy) begin
                        if (!srem_try[D2W-1]) begin
                            r_sx <= srem_try;
                            r_root <= {r_root[RootW-2:0], 1'b1};
                        end else begin
                            r_sx <= {r_sx[D2W-3:0], r_d2[D2W-1:D2W-2]};
                            r_root <= {r_root[RootW-2:0], 1'b0};
                        end
                        r_d2 <= {r_d2[D2W-3:0], 2'b00};
                        r_sstep <= r_sstep + 1'b1;
                        if (r_sstep == 6'(RootW-1)) begin
                            r_sbusy <= 1'b0;
                            r_rsum <= r_rsum + RsumW'({r_root[RootW-2:0],
                                                       ~srem_try[D2W-1]});
                            r_walk <= r_walk + 1'b1;
                            r_ridx <= r_ridx + 1'b1;
                            if (r_walk + 1'b1 == r_cnt) r_sdone <= 1'b1;
                        end
                    end
                    if (n_state == ST_DIV_R) begin
                        r_dsel <= 2'd3;
                        r_dbit <= '0;
                    end
                end
                ST_OUT: if (i_ready) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    for (int k = 0; k < 3; k++) r_sum[k] <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_result = {r_ovf, RadW'(r_quo), r_cen[2], r_cen[1], r_cen[0]};
endmodule
`default_nettype wire

/* rtl/point_cloud_centroid_mean_radius.sv */
// channel | dir | tdata (low bit up)                          | tlast
// s_axis  | in  | point_x, point_y, point_z                   | last_point
// m_axis  | out | centroid_x/y/z, mean_radius, overflowed     | -
// Points load one per cycle while the block collects a set.
// After the last point: three bit-serial divides, then per stored point a
// read, square and sum pipeline plus a digit-serial isqrt; the walk then
// ends and one more bit-serial divide yields the mean radius.
// The result waits in the output register until m_axis_tready.
// i_rst_n is synchronous; it clears count, sums and the overflow flag.
`default_nettype none
module point_cloud_centroid_mean_radius (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,  // point_x, point_y, point_z
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [103:0]      m_axis_tdata   // cx, cy, cz, mean_radius, overflowed, pad
);
    import pccmr_pkg::*;
    logic q_valid, q_ready;
    t_cmd q_cmd;
    logic [3*CoordW+RadW:0] res;

    pccmr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_point(s_axis_tdata), .i_last(s_axis_tlast),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );
    pccmr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res)
    );
    assign m_axis_tdata = {6'd0, res};
endmodule
`default_nettype wire

/* rtl/pccmr_checker.sv */
`default_nettype none
module pccmr_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[103:98] == 6'd0)
        else $error("pad bits set");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");
endmodule
bind point_cloud_centroid_mean_radius pccmr_checker u_chk (.*);
`default_nettype wire
